// File: rtl/alid_pkg.sv
// ----------------------------------------------------------------------------
// alid_pkg: shared definitions for the ordered list block
// Sizes, operation and status codes, cell control type and the sequencer
// states used by the list cells and the top level.
// ----------------------------------------------------------------------------
package alid_pkg;

  // Storage size and derived widths.
  localparam int DEPTH = 16;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int FUNC_W   = 3;
  localparam int POS_W    = 4;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int FILL_W   = 5;

  localparam int IN_FIELDS_W  = FUNC_W + POS_W + VAL_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = STATUS_W + VAL_W + SLOT_W + FILL_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Operation codes.
  typedef enum logic [FUNC_W-1:0] {
    FN_APPEND = 3'd0,
    FN_INSERT = 3'd1,
    FN_UPDATE = 3'd2,
    FN_DELETE = 3'd3,
    FN_READ   = 3'd4
  } func_e_t;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_BADIDX   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e_t;

  // What a cell does with its entry.
  typedef enum logic [1:0] {
    C_HOLD = 2'd0,
    C_LOAD = 2'd1,
    C_SHUP = 2'd2,
    C_DEL  = 2'd3
  } cell_op_e_t;

  // Control word driven into each cell.
  typedef struct packed {
    cell_op_e_t               op;
    logic                     valid;
    logic signed [VAL_W-1:0]  key;
  } cell_ctl_t;

  // Sequencer states.
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e_t;

endpackage

// File: rtl/alid_cell.sv
// ----------------------------------------------------------------------------
// alid_cell: one list entry
// Holds one entry, compares it against the key and, on command, loads the
// key or takes the entry of the neighbor below or above.
// ----------------------------------------------------------------------------
module alid_cell (
  input  logic                                   clk,
  input  alid_pkg::cell_ctl_t                    ctl,
  input  logic                                   hit_in,
  input  logic signed [alid_pkg::VAL_W-1:0]      below_d,
  input  logic signed [alid_pkg::VAL_W-1:0]      above_d,
  output logic signed [alid_pkg::VAL_W-1:0]      d,
  output logic                                   hit_out
);

  logic signed [alid_pkg::VAL_W-1:0] d_r;
  logic signed [alid_pkg::VAL_W-1:0] d_nxt;

  // A match in this cell or any cell below it marks this cell and all
  // cells above as part of the closing gap.
  assign hit_out = hit_in | (ctl.valid & (d_r == ctl.key));
  assign d       = d_r;

  // Next entry value.
  always_comb begin
    d_nxt = d_r;
    case (ctl.op)
      alid_pkg::C_HOLD: d_nxt = d_r;
      alid_pkg::C_LOAD: d_nxt = ctl.key;
      alid_pkg::C_SHUP: d_nxt = below_d;
      alid_pkg::C_DEL: begin
        if (hit_out) begin
          d_nxt = above_d;
        end
      end
      default: d_nxt = d_r;
    endcase
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

endmodule

// File: rtl/array_list_insert_delete.sv
// Ordered list of signed 32-bit entries held in a row of cells.
// A result word is built in the execute state from the captured input word and
// presented from the single output register, which emits one read-out
// entry per cycle while free; no input word is taken until the last one is done.
// Reset (rst_n low, synchronous) empties the list; entry contents are not cleared.
// ----------------------------------------------------------------------------
// array_list_insert_delete: top level of the ordered list block
// A sequencer decodes each input word into per-cell commands for a chain of
// list cells and builds the result words in an output register.
// ----------------------------------------------------------------------------
module array_list_insert_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // func [2:0], position [6:3], item_value [38:7], zero pad [39]
  input  logic [alid_pkg::IN_DATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // status [2:0], element [34:3], slot [38:35], fill_count [43:39], zero pad [47:44]
  output logic [alid_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                out_tlast
);

  localparam int DEPTH = alid_pkg::DEPTH;
  localparam int IDX_W = alid_pkg::IDX_W;
  localparam int CNT_W = alid_pkg::CNT_W;
  localparam int VAL_W = alid_pkg::VAL_W;

  // Control state.
  alid_pkg::state_e_t state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;

  // Captured input word.
  alid_pkg::func_e_t               func_r;
  logic [alid_pkg::POS_W-1:0]      pos_r;
  logic signed [VAL_W-1:0]         val_r;

  // Output register.
  logic                            out_valid_r, out_valid_nxt;
  logic [alid_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                            out_last_r, out_last_nxt;

  // Cell chain signals.
  alid_pkg::cell_ctl_t             ctl [DEPTH];
  logic signed [VAL_W-1:0]         cell_d [DEPTH];
  logic [DEPTH-1:0]                hit;

  logic                            in_fire;
  logic                            out_free;
  logic                            full;
  logic                            found;
  logic [IDX_W-1:0]                at_idx;

  // Result fields assembled in the execute cycle.
  alid_pkg::status_e_t             r_status;
  logic signed [VAL_W-1:0]         r_elem;
  logic [IDX_W-1:0]                r_slot;
  logic [CNT_W-1:0]                r_fill;
  logic                            r_last;
  logic                            r_emit;

  assign in_tready  = (state_r == alid_pkg::S_IDLE);
  assign in_fire    = in_tvalid & in_tready;
  assign out_free   = ~out_valid_r | out_tready;
  assign full       = (count_r == CNT_W'(DEPTH));
  assign found      = hit[DEPTH-1];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Chain of cells: each sees its lower and upper neighbor.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [VAL_W-1:0] below_w;
    logic signed [VAL_W-1:0] above_w;
    logic                    hit_in_w;

    if (g == 0) begin : g_first
      assign below_w  = val_r;
      assign hit_in_w = 1'b0;
    end else begin : g_mid
      assign below_w  = cell_d[g-1];
      assign hit_in_w = hit[g-1];
    end

    if (g == DEPTH - 1) begin : g_top
      assign above_w = '0;
    end else begin : g_below_top
      assign above_w = cell_d[g+1];
    end

    alid_cell u_cell (
      .clk     (clk),
      .ctl     (ctl[g]),
      .hit_in  (hit_in_w),
      .below_d (below_w),
      .above_d (above_w),
      .d       (cell_d[g]),
      .hit_out (hit[g])
    );
  end

  // Index of the first matching valid entry.
  always_comb begin
    at_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (hit[i]) begin
        at_idx = IDX_W'(i);
      end
    end
  end

  // Sequencer: decode the captured word, command the cells and build results.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    rd_idx_nxt = rd_idx_r;
    r_status   = alid_pkg::ST_OK;
    r_elem     = '0;
    r_slot     = '0;
    r_fill     = count_r;
    r_last     = 1'b1;
    r_emit     = 1'b0;

    for (int i = 0; i < DEPTH; i++) begin
      ctl[i].op    = alid_pkg::C_HOLD;
      ctl[i].valid = (i < int'(count_r));
      ctl[i].key   = val_r;
    end

    case (state_r)
      alid_pkg::S_IDLE: begin
        rd_idx_nxt = '0;
        if (in_fire) begin
          state_nxt = alid_pkg::S_EXEC;
        end
      end
      alid_pkg::S_EXEC: begin
        if (out_free) begin
          case (func_r)
            alid_pkg::FN_APPEND: begin
              r_emit    = 1'b1;
              state_nxt = alid_pkg::S_IDLE;
              if (full) begin
                r_status = alid_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (i == int'(count_r)) begin
                    ctl[i].op = alid_pkg::C_LOAD;
                  end
                end
                r_slot    = IDX_W'(count_r);
                count_nxt = count_r + CNT_W'(1);
                r_fill    = count_nxt;
              end
            end
            alid_pkg::FN_INSERT: begin
              r_emit    = 1'b1;
              state_nxt = alid_pkg::S_IDLE;
              if (full) begin
                r_status = alid_pkg::ST_FULL;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  ctl[i].op = alid_pkg::C_SHUP;
                end
                count_nxt = count_r + CNT_W'(1);
                r_fill    = count_nxt;
              end
            end
            alid_pkg::FN_UPDATE: begin
              r_emit    = 1'b1;
              state_nxt = alid_pkg::S_IDLE;
              if (int'(pos_r) >= int'(count_r)) begin
                r_status = alid_pkg::ST_BADIDX;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  if (i == int'(pos_r)) begin
                    ctl[i].op = alid_pkg::C_LOAD;
                  end
                end
                r_slot = IDX_W'(pos_r);
              end
            end
            alid_pkg::FN_DELETE: begin
              r_emit    = 1'b1;
              state_nxt = alid_pkg::S_IDLE;
              if (!found) begin
                r_status = alid_pkg::ST_NOTFOUND;
              end else begin
                for (int i = 0; i < DEPTH; i++) begin
                  ctl[i].op = alid_pkg::C_DEL;
                end
                r_slot    = at_idx;
                count_nxt = count_r - CNT_W'(1);
                r_fill    = count_nxt;
              end
            end
            alid_pkg::FN_READ: begin
              r_emit = 1'b1;
              if (count_r == '0) begin
                r_status  = alid_pkg::ST_EMPTY;
                state_nxt = alid_pkg::S_IDLE;
              end else begin
                r_elem     = cell_d[rd_idx_r];
                r_slot     = rd_idx_r;
                r_last     = ((CNT_W'(rd_idx_r) + CNT_W'(1)) == count_r);
                rd_idx_nxt = rd_idx_r + IDX_W'(1);
                if (r_last) begin
                  state_nxt = alid_pkg::S_IDLE;
                end
              end
            end
            default: begin
              // Unused codes produce nothing.
              state_nxt = alid_pkg::S_IDLE;
            end
          endcase
        end
      end
      default: state_nxt = alid_pkg::S_IDLE;
    endcase
  end

  // Output register: loads a new word when free, drops it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (r_emit) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = r_last;
      out_data_nxt  = alid_pkg::OUT_DATA_W'({
                        alid_pkg::FILL_W'(r_fill),
                        alid_pkg::SLOT_W'(r_slot),
                        r_elem,
                        r_status});
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alid_pkg::S_IDLE;
      count_r     <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    if (in_fire) begin
      func_r <= alid_pkg::func_e_t'(in_tdata[alid_pkg::FUNC_W-1:0]);
      pos_r  <= in_tdata[alid_pkg::FUNC_W +: alid_pkg::POS_W];
      val_r  <= in_tdata[alid_pkg::FUNC_W + alid_pkg::POS_W +: VAL_W];
    end
  end

endmodule

// File: rtl/alid_chk.sv
// ----------------------------------------------------------------------------
// alid_chk: port checker for the ordered list block
// Watches the stream ports of the top level and flags words that break the
// block's handshake or result rules.
// ----------------------------------------------------------------------------
module alid_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [alid_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  logic [alid_pkg::STATUS_W-1:0] st;
  logic [alid_pkg::FILL_W-1:0]   fill;

  assign st   = out_tdata[alid_pkg::STATUS_W-1:0];
  assign fill = out_tdata[alid_pkg::STATUS_W + alid_pkg::VAL_W + alid_pkg::SLOT_W +:
                          alid_pkg::FILL_W];

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // The block is busy for the cycle after it takes an input word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken on consecutive cycles");

  // A failed operation gives a single word.
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st != alid_pkg::ST_OK) |-> out_tlast)
    else $error("failure status without last flag");

  // The fill count never exceeds the list size.
  a_fill_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (int'(fill) <= alid_pkg::DEPTH))
    else $error("fill count beyond list size");

  // An empty read-out reports an empty list.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == alid_pkg::ST_EMPTY) |-> (fill == '0))
    else $error("empty status with nonzero fill count");

endmodule

bind array_list_insert_delete alid_chk u_alid_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// File: test/list_checker.sv
// ----------------------------------------------------------------------------
// list_checker: result checker for the ordered list block
// Watches the input and result streams, keeps its own copy of the list,
// computes the result words that each accepted input word should cause and
// compares every accepted result word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module list_checker
  import alid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  output int                    fail_count,
  output int                    pending
);

  localparam int POS_LSB  = FUNC_W;
  localparam int VAL_LSB  = FUNC_W + POS_W;
  localparam int ELEM_LSB = STATUS_W;
  localparam int SLOT_LSB = STATUS_W + VAL_W;
  localparam int FILL_LSB = STATUS_W + VAL_W + SLOT_W;

  typedef struct {
    status_e_t               status;
    logic signed [VAL_W-1:0] element;
    logic [SLOT_W-1:0]       slot;
    logic [FILL_W-1:0]       fill;
    logic                    last;
  } list_result_t;

  // Result words still owed by the block, oldest first.
  list_result_t want_words[$];

  // Shadow copy of the list contents and its length.
  logic signed [VAL_W-1:0] shadow_cells [DEPTH];
  int                      shadow_fill;
  int                      err_n = 0;

  function automatic list_result_t result_word(status_e_t st, logic signed [VAL_W-1:0] el,
                                               int sl, int fl, logic lst);
    list_result_t r;
    r.status  = st;
    r.element = el;
    r.slot    = SLOT_W'(sl);
    r.fill    = FILL_W'(fl);
    r.last    = lst;
    return r;
  endfunction

  // Apply one list operation to the shadow list and queue its result words.
  task automatic apply_list_op(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                               input logic signed [VAL_W-1:0] val);
    int i;
    int at;
    at = -1;
    case (fn)
      FN_APPEND: begin
        if (shadow_fill >= DEPTH) begin
          want_words.push_back(result_word(ST_FULL, '0, 0, shadow_fill, 1'b1));
        end else begin
          shadow_cells[IDX_W'(shadow_fill)] = val;
          want_words.push_back(result_word(ST_OK, '0, shadow_fill, shadow_fill + 1, 1'b1));
          shadow_fill++;
        end
      end
      FN_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          want_words.push_back(result_word(ST_FULL, '0, 0, shadow_fill, 1'b1));
        end else begin
          for (i = shadow_fill; i > 0; i--)
            shadow_cells[IDX_W'(i)] = shadow_cells[IDX_W'(i-1)];
          shadow_cells[0] = val;
          shadow_fill++;
          want_words.push_back(result_word(ST_OK, '0, 0, shadow_fill, 1'b1));
        end
      end
      FN_UPDATE: begin
        if (int'(pos) >= shadow_fill) begin
          want_words.push_back(result_word(ST_BADIDX, '0, 0, shadow_fill, 1'b1));
        end else begin
          shadow_cells[pos] = val;
          want_words.push_back(result_word(ST_OK, '0, pos, shadow_fill, 1'b1));
        end
      end
      FN_DELETE: begin
        // Only the first match among the valid entries is removed.
        for (i = 0; i < shadow_fill; i++) begin
          if (shadow_cells[IDX_W'(i)] == val) begin
            at = i;
            break;
          end
        end
        if (at < 0) begin
          want_words.push_back(result_word(ST_NOTFOUND, '0, 0, shadow_fill, 1'b1));
        end else begin
          for (i = at + 1; i < shadow_fill; i++)
            shadow_cells[IDX_W'(i-1)] = shadow_cells[IDX_W'(i)];
          shadow_fill--;
          want_words.push_back(result_word(ST_OK, '0, at, shadow_fill, 1'b1));
        end
      end
      FN_READ: begin
        if (shadow_fill == 0) begin
          want_words.push_back(result_word(ST_EMPTY, '0, 0, 0, 1'b1));
        end else begin
          for (i = 0; i < shadow_fill; i++)
            want_words.push_back(result_word(ST_OK, shadow_cells[IDX_W'(i)], i, shadow_fill,
                                             i == shadow_fill - 1));
        end
      end
      default: begin
        // Spare operation codes are ignored by the block.
      end
    endcase
  endtask

  // Sample both streams at each rising edge; results are checked before the
  // new input word is predicted, since a result never belongs to a word
  // accepted at the same edge.
  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      shadow_fill = 0;
      want_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.status  = status_e_t'(out_tdata[STATUS_W-1:0]);
        got.element = out_tdata[ELEM_LSB +: VAL_W];
        got.slot    = out_tdata[SLOT_LSB +: SLOT_W];
        got.fill    = out_tdata[FILL_LSB +: FILL_W];
        got.last    = out_tlast;
        if (want_words.size() == 0) begin
          if (err_n < 10)
            $display("list_checker: unexpected st=%0d elem=%0d slot=%0d fill=%0d last=%0d",
                     got.status, got.element, got.slot, got.fill, got.last);
          err_n++;
        end else begin
          want = want_words.pop_front();
          if (got.status != want.status || got.element != want.element ||
              got.slot != want.slot || got.fill != want.fill || got.last != want.last) begin
            if (err_n < 10) begin
              $display("list_checker: expected st=%0d elem=%0d slot=%0d fill=%0d last=%0d",
                       want.status, want.element, want.slot, want.fill, want.last);
              $display("list_checker:      got st=%0d elem=%0d slot=%0d fill=%0d last=%0d",
                       got.status, got.element, got.slot, got.fill, got.last);
            end
            err_n++;
          end
        end
      end
      if (in_tvalid && in_tready)
        apply_list_op(in_tdata[FUNC_W-1:0], in_tdata[POS_LSB +: POS_W],
                      in_tdata[VAL_LSB +: VAL_W]);
    end
    pending    <= want_words.size();
    fail_count <= err_n;
  end

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench top for the ordered list block
// Drives list operations into the block: a directed opening with the edge
// cases, then random runs that alternately grow and shrink the list, under
// three idling patterns. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb;
  import alid_pkg::*;

  localparam logic [FUNC_W-1:0] FN_SPARE_MIN = 3'd5;
  localparam logic [FUNC_W-1:0] FN_SPARE_MAX = 3'd7;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int ITEMS_PER_PHASE = 152;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  int                    fail_count;
  int                    pending;

  // Idle percentages of the sender and the receiver.
  int tx_idle = 23;
  int rx_idle = 82;

  // Recently sent values, so that deletes often hit an entry.
  logic signed [VAL_W-1:0] recent_vals [16];
  logic [3:0]              recent_ptr = '0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  array_list_insert_delete dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  list_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Receiver stalls at random.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle);
  end

  function automatic logic [IN_DATA_W-1:0] pack_word(logic [FUNC_W-1:0] fn,
                                                     logic [POS_W-1:0] pos,
                                                     logic signed [VAL_W-1:0] val);
    logic [IN_DATA_W-1:0] w;
    w = '0;
    w[FUNC_W-1:0]            = fn;
    w[FUNC_W +: POS_W]       = pos;
    w[FUNC_W + POS_W +: VAL_W] = val;
    return w;
  endfunction

  // Random values: many small ones so that duplicates appear, some extremes.
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 50) return $urandom;
    if (r < 80) return $urandom_range(7);
    case ($urandom_range(3))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      default: return -1;
    endcase
  endfunction

  // Present one word, idling first at random, and hold it until accepted.
  task automatic send_word(input logic [FUNC_W-1:0] fn, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pack_word(fn, pos, val);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    recent_vals[recent_ptr] = val;
    recent_ptr = recent_ptr + 4'd1;
  endtask

  // Hold off the sender until every expected result word has arrived.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // One random operation; grow mode favors append and insert, shrink mode delete.
  task automatic random_item(input bit grow);
    int r;
    logic signed [VAL_W-1:0] v;
    r = $urandom_range(99);
    if (r < (grow ? 40 : 10)) begin
      send_word(FN_APPEND, POS_W'($urandom_range(15)), pick_value());
    end else if (r < (grow ? 65 : 18)) begin
      send_word(FN_INSERT, POS_W'($urandom_range(15)), pick_value());
    end else if (r < (grow ? 77 : 30)) begin
      send_word(FN_UPDATE, POS_W'($urandom_range(15)), pick_value());
    end else if (r < (grow ? 87 : 80)) begin
      v = ($urandom_range(99) < 80) ? recent_vals[4'($urandom_range(15))] : pick_value();
      send_word(FN_DELETE, POS_W'($urandom_range(15)), v);
    end else if (r < (grow ? 97 : 93)) begin
      send_word(FN_READ, POS_W'($urandom_range(15)), $urandom);
    end else begin
      send_word(FUNC_W'($urandom_range(FN_SPARE_MAX, FN_SPARE_MIN)),
                POS_W'($urandom_range(15)), $urandom);
    end
  endtask

  initial begin : stimulus
    int f;
    int ph;
    int n;
    recent_vals = '{default: '0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening: empty list cases, spare codes, extremes, duplicates.
    send_word(FN_READ, 0, 0);
    send_word(FN_DELETE, 0, 5);
    send_word(FN_UPDATE, 0, 1);
    for (f = FN_SPARE_MIN; f <= FN_SPARE_MAX; f++) send_word(FUNC_W'(f), 4'hf, -1);
    send_word(FN_APPEND, 4'hf, VAL_MIN);
    send_word(FN_APPEND, 0, VAL_MAX);
    send_word(FN_INSERT, 0, -1);
    send_word(FN_UPDATE, 2, 0);
    send_word(FN_UPDATE, 3, 7);
    send_word(FN_INSERT, 0, VAL_MIN);
    send_word(FN_DELETE, 0, VAL_MIN);
    send_word(FN_DELETE, 0, 12345);
    send_word(FN_READ, 0, 0);

    // Random runs under three idling patterns.
    for (ph = 0; ph < 3; ph++) begin
      wait_for_results();
      case (ph)
        0: begin tx_idle = 23; rx_idle = 82; end
        1: begin tx_idle = 82; rx_idle = 23; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      for (n = 0; n < ITEMS_PER_PHASE; n++) random_item(((n / 30) % 2) == 0);
    end

    wait_for_results();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
